FILE: rtl/mf3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_pkg: shared definitions for the 3x3 median filter
// Widths, size limits, configuration register indexes and the stage-enable
// struct that the top level passes to the median datapath.
// ----------------------------------------------------------------------------
package mf3_pkg;

	localparam int unsigned MAX_WIDTH  = 512;
	localparam int unsigned MAX_HEIGHT = 512;
	localparam int unsigned MIN_SIZE   = 3;

	localparam int unsigned PIX_W  = 8;
	localparam int unsigned SIZE_W = 10;
	localparam int unsigned POS_W  = 9;
	localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
	localparam int unsigned IDX_W  = 1;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [8:0]       win9_t;

	// Load enables for the two register stages of the median datapath.
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} med_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/mf3_median.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_median: pipelined median of nine pixels
// Stage two sorts each group of three; stage three takes the maximum of the
// minimums, the median of the medians and the minimum of the maximums. The
// median of those three, formed after stage three, is the median of nine.
// ----------------------------------------------------------------------------
module mf3_median (
	input  wire logic               clk,
	input  wire mf3_pkg::med_ctrl_t ctrl,
	input  wire mf3_pkg::win9_t     win,
	output mf3_pkg::pix_t           med
);

	function automatic mf3_pkg::pix_t min2(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic mf3_pkg::pix_t max2(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic mf3_pkg::pix_t med3(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b,
			input mf3_pkg::pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	mf3_pkg::pix_t lo_s2 [3];
	mf3_pkg::pix_t md_s2 [3];
	mf3_pkg::pix_t hi_s2 [3];

	mf3_pkg::pix_t lo_max_s3;
	mf3_pkg::pix_t md_med_s3;
	mf3_pkg::pix_t hi_min_s3;

	always_ff @(posedge clk) begin
		if (ctrl.en_s2) begin
			for (int k = 0; k < 3; k++) begin
				lo_s2[k] <= min2(min2(win[3*k], win[3*k+1]), win[3*k+2]);
				md_s2[k] <= med3(win[3*k], win[3*k+1], win[3*k+2]);
				hi_s2[k] <= max2(max2(win[3*k], win[3*k+1]), win[3*k+2]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s3) begin
			lo_max_s3 <= max2(max2(lo_s2[0], lo_s2[1]), lo_s2[2]);
			md_med_s3 <= med3(md_s2[0], md_s2[1], md_s2[2]);
			hi_min_s3 <= min2(min2(hi_s2[0], hi_s2[1]), hi_s2[2]);
		end
	end

	assign med = med3(lo_max_s3, md_med_s3, hi_min_s3);

endmodule
`default_nettype wire

FILE: rtl/median_filter_3x3_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// median_filter_3x3_core: streaming 3x3 median filter for 8-bit pixels
// Takes grayscale pixels in raster order and returns the median of every
// interior 3x3 neighbourhood together with the position of its center.
// ----------------------------------------------------------------------------
// Pixels enter one per transfer in raster order; frame_start marks pixel
// (0,0) and clears the position counters, and a frame also wraps by itself
// after its last pixel. When pixel (r,c) arrives with r >= 2 and c >= 2, one
// result follows: the median of the nine pixels centered on (r-1,c-1), with
// out_row = r-1 and out_col = c-1. Border pixels produce no transfer on the
// output. Unless the output stalls, the block sustains one pixel per clock:
// the line store is a single 512 x 16 memory (rows r-1 and r-2 of one
// column packed in one word) that is read and written once each per cycle,
// and a pixel taken at the same edge at which the previous one writes back
// the same column is served by forwarding. Once its pixel is taken, a result
// passes in order through the memory read loaded at the transfer edge, the
// column sort, the merge and the output register. When the output stalls,
// pixels are still taken until four results wait inside the block (output
// register, merge, sort and stage one), and only then does in_ready drop;
// border pixels pass stage one freely and do not count toward those four.
// Width and height are sampled through the configuration port and clamped to
// 3..512; write them only while idle. The line store is not cleared: each
// frame writes its first two rows before it reads them, so no clearing pass
// follows reset.
// ----------------------------------------------------------------------------
module median_filter_3x3_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration port
	input  wire logic                                 cfg_we,
	input  wire logic [mf3_pkg::IDX_W-1:0]            cfg_index,
	input  wire logic [mf3_pkg::SIZE_W-1:0]           cfg_data,
	// pixel input
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [mf3_pkg::PIX_W-1:0]            pixel,
	input  wire logic                                 frame_start,
	// filtered output
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [mf3_pkg::POS_W-1:0]                 out_row,
	output logic [mf3_pkg::POS_W-1:0]                 out_col,
	output logic [mf3_pkg::PIX_W-1:0]                 median_value
);

	localparam int unsigned SW = mf3_pkg::SIZE_W;
	localparam int unsigned PW = mf3_pkg::POS_W;
	localparam int unsigned AW = mf3_pkg::ADDR_W;
	localparam int unsigned XW = mf3_pkg::PIX_W;

	localparam logic [SW-1:0] MIN_SZ = SW'(mf3_pkg::MIN_SIZE);
	localparam logic [SW-1:0] MAX_W  = SW'(mf3_pkg::MAX_WIDTH);
	localparam logic [SW-1:0] MAX_H  = SW'(mf3_pkg::MAX_HEIGHT);

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [SW-1:0] image_width_q;
	logic [SW-1:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= SW'(352);
			image_height_q <= SW'(288);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mf3_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				mf3_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
			endcase
		end
	end

	// Effective sizes, clamped to the supported range.
	logic [SW-1:0] w_eff;
	logic [SW-1:0] h_eff;

	always_comb begin
		priority if (image_width_q < MIN_SZ) w_eff = MIN_SZ;
		else if (image_width_q > MAX_W)      w_eff = MAX_W;
		else                                 w_eff = image_width_q;
		priority if (image_height_q < MIN_SZ) h_eff = MIN_SZ;
		else if (image_height_q > MAX_H)      h_eff = MAX_H;
		else                                  h_eff = image_height_q;
	end

	// ------------------------------------------------------------------
	// Pipeline flow control. Each stage moves when the next one is empty
	// or moving. Pixels that produce no result leave after stage one.
	// ------------------------------------------------------------------
	logic valid_s1, emit_s1;
	logic valid_s2, valid_s3;
	logic out_valid_q;
	logic free3, free2, s1_go, s1_leave;
	logic ld2, ld3, ld_out, accept;

	assign free3    = !valid_s3 || !out_valid_q || out_ready;
	assign ld3      = valid_s2 && free3;
	assign free2    = !valid_s2 || free3;
	assign s1_go    = !emit_s1 || free2;
	assign s1_leave = valid_s1 && s1_go;
	assign ld2      = s1_leave && emit_s1;
	assign ld_out   = valid_s3 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_go;
	assign accept   = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Position counters: frame start, wrap on a shrunk size, advance.
	// ------------------------------------------------------------------
	logic [PW-1:0] row_q, col_q;
	logic [SW-1:0] row_a, col_a, row_p1, col_p1, row_n, col_n;
	logic          emit_a;

	always_comb begin
		row_a = frame_start ? '0 : {1'b0, row_q};
		col_a = frame_start ? '0 : {1'b0, col_q};
		if (col_a >= w_eff) begin
			col_a = '0;
			row_a = row_a + SW'(1);
		end
		if (row_a >= h_eff) begin
			row_a = '0;
		end
		row_p1 = row_a + SW'(1);
		col_p1 = col_a + SW'(1);
		if (col_p1 >= w_eff) begin
			col_n = '0;
			row_n = (row_p1 >= h_eff) ? '0 : row_p1;
		end else begin
			col_n = col_p1;
			row_n = row_a;
		end
		emit_a = (row_a >= SW'(2)) && (col_a >= SW'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			row_q <= row_n[PW-1:0];
			col_q <= col_n[PW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Line store: word c holds {row r-2, row r-1} of column c. It is read
	// when a pixel is taken and written when that pixel leaves stage one.
	// ------------------------------------------------------------------
	logic [2*XW-1:0] line_mem [mf3_pkg::MAX_WIDTH];
	logic [2*XW-1:0] rd_q;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   addr_s1;
	logic [2*XW-1:0] wr_data;
	logic [2*XW-1:0] line_s1;
	logic [XW-1:0]   top_s1, mid_s1;

	assign rd_addr = col_a[AW-1:0];

	always_ff @(posedge clk) begin
		if (s1_leave) begin
			line_mem[addr_s1] <= wr_data;
		end
		if (accept) begin
			rd_q <= line_mem[rd_addr];
		end
	end

	// Stage one registers. A pixel taken in the same cycle that the
	// previous one writes its column gets the fresh word by forwarding,
	// since the memory returns the old contents in that case.
	logic            fwd_s1;
	logic [2*XW-1:0] fwd_data_s1;
	logic [XW-1:0]   pix_s1;
	logic [PW-1:0]   row_s1, col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_leave) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1     <= emit_a;
			addr_s1     <= rd_addr;
			pix_s1      <= pixel;
			row_s1      <= PW'(row_a - SW'(1));
			col_s1      <= PW'(col_a - SW'(1));
			fwd_s1      <= s1_leave && (addr_s1 == rd_addr);
			fwd_data_s1 <= wr_data;
		end
	end

	assign line_s1 = fwd_s1 ? fwd_data_s1 : rd_q;
	assign top_s1  = line_s1[2*XW-1:XW];
	assign mid_s1  = line_s1[XW-1:0];
	// Row r-1 moves up to r-2; the new pixel becomes row r-1.
	assign wr_data = {mid_s1, pix_s1};

	// ------------------------------------------------------------------
	// Window registers: the two previous columns of the 3x3 window, in
	// the order top, middle, bottom of column c-2 and then column c-1.
	// ------------------------------------------------------------------
	mf3_pkg::pix_t  win_q [6];
	mf3_pkg::win9_t win_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++) begin
				win_q[k] <= '0;
			end
		end else if (s1_leave) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= pix_s1;
		end
	end

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			win_s1[k] = win_q[k];
		end
		win_s1[6] = top_s1;
		win_s1[7] = mid_s1;
		win_s1[8] = pix_s1;
	end

	// ------------------------------------------------------------------
	// Median datapath and the position that travels beside it.
	// ------------------------------------------------------------------
	mf3_pkg::med_ctrl_t med_ctrl;
	mf3_pkg::pix_t      med;
	logic [PW-1:0]      row_s2, col_s2, row_s3, col_s3;

	assign med_ctrl.en_s2 = ld2;
	assign med_ctrl.en_s3 = ld3;

	mf3_median u_median (
		.clk  (clk),
		.ctrl (med_ctrl),
		.win  (win_s1),
		.med  (med)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ld2) begin
				valid_s2 <= 1'b1;
			end else if (ld3) begin
				valid_s2 <= 1'b0;
			end
			if (ld3) begin
				valid_s3 <= 1'b1;
			end else if (ld_out) begin
				valid_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			row_s2 <= row_s1;
			col_s2 <= col_s1;
		end
		if (ld3) begin
			row_s3 <= row_s2;
			col_s3 <= col_s2;
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	logic [PW-1:0] out_row_q, out_col_q;
	logic [XW-1:0] median_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_row_q <= row_s3;
			out_col_q <= col_s3;
			median_q  <= med;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_row      = out_row_q;
	assign out_col      = out_col_q;
	assign median_value = median_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
`ifndef SYNTHESIS
	// A result is always for an interior position.
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_row != '0) && (out_col != '0))
		else $error("result for a border position");

	// While stage one holds its pixel, the memory read data must not move.
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_leave |=> $stable(rd_q))
		else $error("line store read data changed under a held pixel");

	// An empty stage one always lets a pixel in.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input blocked with stage one empty");

	// Forwarding is only ever selected for a pixel that follows another.
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !valid_s1 |=> !fwd_s1)
		else $error("forwarding selected without a preceding write");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_median_filter_3x3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_median_filter_3x3_core: self-checking bench for the 3x3 median filter
// Streams frames of many sizes through the core, predicts every interior
// median with an untimed line-buffer model and compares each output transfer
// field by field, under random idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_median_filter_3x3_core;

	// Random pixels to send after the directed table.
	localparam int unsigned RAND_ITEMS    = 340;
	// Cycles to let pass once the last result is in. The pipeline is four deep,
	// and pixels that make no result may still be in flight behind it.
	localparam int unsigned SETTLE_CYCLES = 12;
	// Length of the one long receiver hold-off.
	localparam int unsigned HOLD_CYCLES   = 100;
	localparam int unsigned DIR_ROWS      = 28;

	// Kinds of pixel content.
	localparam int unsigned PIX_FULL    = 0;
	localparam int unsigned PIX_EXTREME = 1;
	localparam int unsigned PIX_BAND    = 2;

	// One filtered pixel as the core reports it.
	typedef struct packed {
		logic [mf3_pkg::POS_W-1:0] row;
		logic [mf3_pkg::POS_W-1:0] col;
		mf3_pkg::pix_t             med;
	} median_res_t;

	// One row of the directed table. When typed is set, the result that this
	// pixel causes is written out by hand instead of taken from the predictor.
	typedef struct packed {
		mf3_pkg::pix_t             pix;
		logic                      fs;
		logic                      typed;
		logic [mf3_pkg::POS_W-1:0] row;
		logic [mf3_pkg::POS_W-1:0] col;
		mf3_pkg::pix_t             med;
	} dir_row_t;

	// ------------------------------------------------------------------------
	// Clock, reset and the signals around the core. Every input has a known
	// value from time zero.
	// ------------------------------------------------------------------------
	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       cfg_we      = 1'b0;
	logic [mf3_pkg::IDX_W-1:0]  cfg_index   = '0;
	logic [mf3_pkg::SIZE_W-1:0] cfg_data    = '0;
	logic                       in_valid    = 1'b0;
	logic                       in_ready;
	mf3_pkg::pix_t              pixel       = '0;
	logic                       frame_start = 1'b0;
	logic                       out_valid;
	logic                       out_ready   = 1'b0;
	logic [mf3_pkg::POS_W-1:0]  out_row;
	logic [mf3_pkg::POS_W-1:0]  out_col;
	mf3_pkg::pix_t              median_value;

	always #6 clk = ~clk;

	median_filter_3x3_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel        (pixel),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_row      (out_row),
		.out_col      (out_col),
		.median_value (median_value)
	);

	// ------------------------------------------------------------------------
	// Predictor state: the size registers as last written, the position of
	// the next pixel, the two previous rows and the two previous window
	// columns. The ok flags record which line entries hold a pixel of some
	// frame, so that a size change without a frame start is only made where
	// the core never has to read an entry that was never written.
	// ------------------------------------------------------------------------
	logic [mf3_pkg::SIZE_W-1:0] reg_width  = mf3_pkg::SIZE_W'(352);
	logic [mf3_pkg::SIZE_W-1:0] reg_height = mf3_pkg::SIZE_W'(288);
	int unsigned                pos_row    = 0;
	int unsigned                pos_col    = 0;
	mf3_pkg::pix_t              prev_line  [mf3_pkg::MAX_WIDTH];
	mf3_pkg::pix_t              prev2_line [mf3_pkg::MAX_WIDTH];
	bit                         prev_ok    [mf3_pkg::MAX_WIDTH];
	bit                         prev2_ok   [mf3_pkg::MAX_WIDTH];
	mf3_pkg::pix_t              win_hist   [6] = '{default: '0};

	median_res_t median_q [$];
	int unsigned n_bad     = 0;
	int unsigned n_rand    = 0;
	bit          src_gaps  = 1'b0;
	bit          sink_gaps = 1'b0;
	bit          hold_req  = 1'b0;
	bit          pause_req = 1'b0;
	dir_row_t    dir_tab [DIR_ROWS];

	// Effective size: the register clamped to 3 .. max.
	function automatic int unsigned eff_size(input logic [mf3_pkg::SIZE_W-1:0] v,
			input int unsigned maxv);
		if (v < mf3_pkg::MIN_SIZE) return mf3_pkg::MIN_SIZE;
		if (v > maxv) return maxv;
		return v;
	endfunction

	// Fifth smallest of nine: the value with at most four below it and at
	// least five at or below it.
	function automatic mf3_pkg::pix_t median_of_nine(input mf3_pkg::win9_t v);
		int unsigned below;
		int unsigned same;
		for (int i = 0; i < 9; i++) begin
			below = 0;
			same  = 0;
			for (int j = 0; j < 9; j++) begin
				if (v[j] < v[i]) below++;
				else if (v[j] == v[i]) same++;
			end
			if (below <= 4 && below + same > 4) return v[i];
		end
		return v[0];
	endfunction

	// True when both line rows hold written pixels for every column below w.
	function automatic bit store_covers(input int unsigned w);
		for (int unsigned c = 0; c < w; c++) begin
			if (!prev_ok[c] || !prev2_ok[c]) return 1'b0;
		end
		return 1'b1;
	endfunction

	// Advances the predictor by one accepted pixel and says whether it
	// completes an interior neighbourhood, and if so which median it yields.
	task automatic filter_pixel(input mf3_pkg::pix_t p, input logic fs, output bit hit,
			output median_res_t res);
		int unsigned    w;
		int unsigned    h;
		int unsigned    c;
		mf3_pkg::pix_t  top;
		mf3_pkg::pix_t  mid;
		mf3_pkg::win9_t win;
		w   = eff_size(reg_width, mf3_pkg::MAX_WIDTH);
		h   = eff_size(reg_height, mf3_pkg::MAX_HEIGHT);
		hit = 1'b0;
		res = '0;
		if (fs) begin
			pos_row = 0;
			pos_col = 0;
		end
		// A width or height that shrank under the current position wraps it.
		if (pos_col >= w) begin
			pos_col = 0;
			pos_row++;
		end
		if (pos_row >= h) pos_row = 0;
		c   = pos_col;
		mid = prev_line[c];
		top = prev2_line[c];
		if (pos_row >= 2 && c >= 2) begin
			for (int i = 0; i < 6; i++) win[i] = win_hist[i];
			win[6]  = top;
			win[7]  = mid;
			win[8]  = p;
			hit     = 1'b1;
			res.row = mf3_pkg::POS_W'(pos_row - 1);
			res.col = mf3_pkg::POS_W'(c - 1);
			res.med = median_of_nine(win);
		end
		for (int i = 0; i < 3; i++) win_hist[i] = win_hist[i + 3];
		win_hist[3]   = top;
		win_hist[4]   = mid;
		win_hist[5]   = p;
		prev2_ok[c]   = prev_ok[c];
		prev_ok[c]    = 1'b1;
		prev2_line[c] = mid;
		prev_line[c]  = p;
		pos_col       = c + 1;
		if (pos_col >= w) begin
			pos_col = 0;
			pos_row++;
			if (pos_row >= h) pos_row = 0;
		end
	endtask

	// Offers one pixel, holds it until the transfer happens, then records
	// what the core owes for it. A random gap with valid low may come first.
	task automatic send_pixel(input mf3_pkg::pix_t p, input logic fs, input bit typed,
			input median_res_t typed_res);
		bit          hit;
		median_res_t res;
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel       <= p;
		frame_start <= fs;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		filter_pixel(p, fs, hit, res);
		if (typed) median_q.push_back(typed_res);
		else if (hit) median_q.push_back(res);
	endtask

	// Drops valid, waits for every owed result, then lets the pipeline settle
	// so that a register write finds the core idle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (median_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes width and/or height on consecutive edges; the write enable drops
	// only once, after the last of them.
	task automatic write_sizes(input bit set_w, input logic [mf3_pkg::SIZE_W-1:0] w,
			input bit set_h, input logic [mf3_pkg::SIZE_W-1:0] h);
		if (set_w) begin
			cfg_we    <= 1'b1;
			cfg_index <= mf3_pkg::REG_IMAGE_WIDTH;
			cfg_data  <= w;
			@(posedge clk);
			reg_width = w;
		end
		if (set_h) begin
			cfg_we    <= 1'b1;
			cfg_index <= mf3_pkg::REG_IMAGE_HEIGHT;
			cfg_data  <= h;
			@(posedge clk);
			reg_height = h;
		end
		cfg_we <= 1'b0;
	endtask

	// Pixel content: full range, the two extremes only, or a narrow band with
	// many equal values so that ties in the median are common.
	function automatic mf3_pkg::pix_t pick_pixel(input int unsigned mode);
		case (mode)
			PIX_EXTREME: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
			PIX_BAND:    return mf3_pkg::pix_t'($urandom_range(100, 103));
			default:     return mf3_pkg::pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	// Sends whole frames at the current size. Later frames sometimes rely on
	// the automatic wrap instead of a frame start. With noise enabled, a stray
	// frame start now and then breaks a frame off early.
	task automatic send_frames(input int unsigned nframes, input bit fs_first,
			input int unsigned mode, input bit noise);
		int unsigned npix;
		bit          fs;
		npix = eff_size(reg_width, mf3_pkg::MAX_WIDTH)
			* eff_size(reg_height, mf3_pkg::MAX_HEIGHT);
		for (int unsigned f = 0; f < nframes; f++) begin
			for (int unsigned k = 0; k < npix; k++) begin
				fs = (k == 0) && ((f == 0) ? fs_first : ($urandom_range(0, 1) == 1));
				if (noise && $urandom_range(0, 79) == 0) fs = 1'b1;
				send_pixel(pick_pixel(mode), fs, 1'b0, '0);
				n_rand++;
				// Sender pause in mid-frame until every owed result is in.
				if (pause_req && f == 0 && k == npix / 2) begin
					pause_req = 1'b0;
					wait_idle();
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver. Each pass through the loop drives out_ready once and then waits
	// on the clock. The long hold-off is counted here, so the sender keeps
	// offering pixels while the core fills up and drops in_ready.
	// ------------------------------------------------------------------------
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output checker. Outputs are sampled at the edge, before any update of
	// that edge lands, and each transfer is matched with the oldest
	// expectation. Only the first ten mismatches are printed.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		median_res_t want;
		median_res_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{row: out_row, col: out_col, med: median_value};
			if (median_q.size() == 0) begin
				if (n_bad < 10)
					$display("unexpected output transfer: row %0d col %0d median %0d",
						out_row, out_col, median_value);
				n_bad++;
			end else begin
				want = median_q.pop_front();
				if (got !== want) begin
					if (n_bad < 10)
						$display("mismatch: expected row %0d col %0d median %0d,",
							want.row, want.col, want.med,
							" got row %0d col %0d median %0d",
							out_row, out_col, median_value);
					n_bad++;
				end
			end
		end
	end

	// Hard stop in case the core hangs; far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus sequence.
	// ------------------------------------------------------------------------
	initial begin
		logic [mf3_pkg::SIZE_W-1:0] nw;
		logic [mf3_pkg::SIZE_W-1:0] nh;
		bit                         set_w;
		bit                         set_h;
		bit                         fs_first;
		int unsigned                mode;
		int unsigned                phase;
		int unsigned                npix;

		// Three 3x3 frames. All-white and all-black give the pixel extremes,
		// the mixed frame arrives by the automatic wrap without a frame start,
		// and the black frame follows a frame start in the middle of a frame.
		dir_tab = '{
			'{8'd255, 1'b1, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd255, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd255, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd255, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd255, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd255, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd255, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd255, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd255, 1'b0, 1'b1, 9'd1, 9'd1, 8'd255},
			'{8'd0,   1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd255, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd7,   1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd3,   1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd200, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd9,   1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd1,   1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd128, 1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd64,  1'b0, 1'b1, 9'd1, 9'd1, 8'd9},
			'{8'd77,  1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd0,   1'b1, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd0,   1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd0,   1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd0,   1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd0,   1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd0,   1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd0,   1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd0,   1'b0, 1'b0, 9'd0, 9'd0, 8'd0},
			'{8'd0,   1'b0, 1'b1, 9'd1, 9'd1, 8'd0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the smallest size, with no idling on either side.
		write_sizes(1'b1, mf3_pkg::SIZE_W'(3), 1'b1, mf3_pkg::SIZE_W'(3));
		for (int i = 0; i < DIR_ROWS; i++) begin
			send_pixel(dir_tab[i].pix, dir_tab[i].fs, dir_tab[i].typed,
				'{row: dir_tab[i].row, col: dir_tab[i].col, med: dir_tab[i].med});
		end

		// Random phases of small frames. Each phase writes one or both sizes,
		// sometimes below the minimum. Without a frame start the new size
		// applies in mid-frame, which is only done where the line store is
		// already written for every column in use. A phase may end with a
		// partial frame, so the next size change lands mid-frame. The second
		// phase uses a fixed 8x6 size and no sender idling, so that the long
		// receiver hold-off fills the core and stalls its input.
		n_rand = 0;
		phase  = 0;
		while (n_rand < RAND_ITEMS || phase < 4) begin
			wait_idle();
			nw    = ($urandom_range(0, 7) == 0) ? mf3_pkg::SIZE_W'($urandom_range(0, 2))
				: mf3_pkg::SIZE_W'($urandom_range(3, 10));
			nh    = ($urandom_range(0, 7) == 0) ? mf3_pkg::SIZE_W'($urandom_range(0, 2))
				: mf3_pkg::SIZE_W'($urandom_range(3, 6));
			set_w = ($urandom_range(0, 3) != 0);
			set_h = ($urandom_range(0, 3) != 0);
			if (!set_w && !set_h) set_h = 1'b1;
			if (phase == 1) begin
				nw    = mf3_pkg::SIZE_W'(8);
				nh    = mf3_pkg::SIZE_W'(6);
				set_w = 1'b1;
				set_h = 1'b1;
			end
			write_sizes(set_w, nw, set_h, nh);
			fs_first = !store_covers(eff_size(reg_width, mf3_pkg::MAX_WIDTH))
				|| ($urandom_range(0, 1) == 1);
			// Idling on some phases only; the closing stretch runs without it.
			src_gaps  = (n_rand < RAND_ITEMS * 3 / 4) && ($urandom_range(0, 3) != 0);
			sink_gaps = (n_rand < RAND_ITEMS * 3 / 4) && ($urandom_range(0, 3) != 0);
			if (phase == 1) begin
				src_gaps = 1'b0;
				hold_req = 1'b1;
			end
			if (phase == 3) pause_req = 1'b1;
			mode = $urandom_range(PIX_FULL, PIX_BAND);
			send_frames($urandom_range(1, 3), fs_first, mode, 1'b1);
			if ($urandom_range(0, 2) == 0) begin
				npix = eff_size(reg_width, mf3_pkg::MAX_WIDTH)
					* eff_size(reg_height, mf3_pkg::MAX_HEIGHT);
				repeat ($urandom_range(1, npix - 1)) begin
					send_pixel(pick_pixel(mode), 1'b0, 1'b0, '0);
					n_rand++;
				end
			end
			phase++;
		end

		// Drain: every owed result, then a few quiet cycles in which any
		// extra transfer would be caught by the checker.
		in_valid <= 1'b0;
		while (median_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (n_bad == 0 && median_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/mf3_pkg.sv
rtl/mf3_median.sv
rtl/median_filter_3x3_core.sv
tb/sv/tb_median_filter_3x3_core.sv
